@@ rtl/tcpp_pkg.sv @@
// Shared types, opcodes and the fixed palette for the two-color pixel plotter.
// Used by the controller, the datapath and the top level; no dependencies.
package tcpp_pkg;

    localparam int ADDR_W = 13;

    typedef enum logic [2:0] {
        OP_READ_PIXEL = 3'd0,
        OP_PAINT      = 3'd1,
        OP_RECOLOR    = 3'd2,
        OP_WRITE_BYTE = 3'd3,
        OP_READ_BYTE  = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        pixel_x;
        logic [7:0]        pixel_y;
        logic [3:0]        new_color;
        logic              table_select;
        logic [ADDR_W-1:0] table_address;
        logic [7:0]        table_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  pixel_index;
        logic [14:0] pixel_rgb;
        logic [7:0]  table_byte;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic [23:0] palette24(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h000000;
            4'd2:    c = 24'h21c842;
            4'd3:    c = 24'h5edc78;
            4'd4:    c = 24'h5455ed;
            4'd5:    c = 24'h7d76fc;
            4'd6:    c = 24'hd4524d;
            4'd7:    c = 24'h42ebf5;
            4'd8:    c = 24'hfc5554;
            4'd9:    c = 24'hff7978;
            4'd10:   c = 24'hd4c154;
            4'd11:   c = 24'he6ce80;
            4'd12:   c = 24'h21b03b;
            4'd13:   c = 24'hc95bba;
            4'd14:   c = 24'hcccccc;
            default: c = 24'hffffff;
        endcase
        return c;
    endfunction

    // Blue in the top five bits, red in the bottom five.
    function automatic logic [14:0] to_rgb555(input logic [3:0] idx);
        logic [23:0] c;
        c = palette24(idx);
        return {c[7:3], c[15:11], c[23:19]};
    endfunction

endpackage

@@ rtl/tcpp_ctrl.sv @@
// Sequencing state machine for the pixel plotter: accept, then execute.
// Depends on tcpp_pkg for the command and status structs.
module tcpp_ctrl
    import tcpp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result register must be free before the tables are updated.
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/tcpp_datapath.sv @@
// Table memories, read-modify-write logic and result register of the plotter.
// Depends on tcpp_pkg for item types, opcodes and the palette function.
module tcpp_datapath
    import tcpp_pkg::*;
#(
    parameter int TABLE_BYTES = 6144
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    logic [7:0] pat_mem [TABLE_BYTES];
    logic [7:0] col_mem [TABLE_BYTES];

    in_item_t   item_reg;
    logic [7:0] pat_q_reg;
    logic [7:0] col_q_reg;
    logic       m_valid_reg;
    out_item_t  out_reg;

    function automatic logic in_range(input logic [ADDR_W-1:0] a);
        return {1'b0, a} < (ADDR_W + 1)'(TABLE_BYTES);
    endfunction

    // Byte address of a pixel: row of cells, column of cells, line in cell.
    logic [ADDR_W-1:0] s_pix_addr, s_rd_addr;
    logic              s_is_raw;

    always_comb begin
        s_pix_addr = {s_data.pixel_y[7:3], s_data.pixel_x[7:3], s_data.pixel_y[2:0]};
        s_is_raw   = (s_data.opcode == OP_WRITE_BYTE) || (s_data.opcode == OP_READ_BYTE);
        s_rd_addr  = s_is_raw ? s_data.table_address : s_pix_addr;
        if (!in_range(s_rd_addr)) begin
            s_rd_addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg  <= s_data;
            pat_q_reg <= pat_mem[s_rd_addr];
            col_q_reg <= col_mem[s_rd_addr];
        end
    end

    // Execute stage, working on the latched item and the fetched bytes.
    logic [ADDR_W-1:0] pix_addr;
    logic              pix_ok, raw_ok;
    logic [7:0]        bitm;
    logic [3:0]        fg, bg, nc;
    logic [7:0]        p, c;
    logic [7:0]        p_new, c_new, p_rc;
    logic [3:0]        idx;
    logic              pat_we, col_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        pat_wd, col_wd;
    out_item_t         out_next;

    always_comb begin
        pix_addr = {item_reg.pixel_y[7:3], item_reg.pixel_x[7:3], item_reg.pixel_y[2:0]};
        pix_ok   = in_range(pix_addr);
        raw_ok   = in_range(item_reg.table_address);
        bitm     = 8'h80 >> item_reg.pixel_x[2:0];
        p        = pat_q_reg;
        c        = col_q_reg;
        fg       = c[7:4];
        bg       = c[3:0];
        nc       = item_reg.new_color;
        p_new    = p;
        c_new    = c;
        p_rc     = (fg == bg) ? 8'h00 : p;

        case (item_reg.opcode)
            OP_PAINT: begin
                if (fg == bg || p == 8'h00) begin
                    c_new = {nc, bg};
                    p_new = bitm;
                end else if (p == 8'hFF) begin
                    // Solid cell: the old foreground becomes the background.
                    c_new = {nc, fg};
                    p_new = bitm;
                end else if (fg == nc) begin
                    p_new = p | bitm;
                end else if (bg == nc) begin
                    p_new = p & ~bitm;
                end else if ((p & bitm) != 8'h00) begin
                    c_new = {nc, bg};
                end else begin
                    c_new = {fg, nc};
                end
            end
            OP_RECOLOR: begin
                p_new = p_rc;
                if ((p_rc & bitm) != 8'h00) begin
                    c_new = {nc, bg};
                end else begin
                    c_new = {fg, nc};
                end
            end
            default: begin
            end
        endcase

        idx = ((p_new & bitm) != 8'h00) ? c_new[7:4] : c_new[3:0];

        pat_we  = 1'b0;
        col_we  = 1'b0;
        wr_addr = pix_addr;
        pat_wd  = p_new;
        col_wd  = c_new;
        out_next = '0;
        case (item_reg.opcode)
            OP_READ_PIXEL, OP_PAINT, OP_RECOLOR: begin
                if (pix_ok) begin
                    pat_we               = (item_reg.opcode != OP_READ_PIXEL);
                    col_we               = (item_reg.opcode != OP_READ_PIXEL);
                    out_next.pixel_index = idx;
                    out_next.pixel_rgb   = to_rgb555(idx);
                end
            end
            OP_WRITE_BYTE: begin
                wr_addr = item_reg.table_address;
                pat_wd  = item_reg.table_data;
                col_wd  = item_reg.table_data;
                pat_we  = raw_ok && !item_reg.table_select;
                col_we  = raw_ok && item_reg.table_select;
            end
            OP_READ_BYTE: begin
                if (raw_ok) begin
                    out_next.table_byte = item_reg.table_select ? c : p;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && pat_we) begin
            pat_mem[wr_addr] <= pat_wd;
        end
        if (cmd.exec && col_we) begin
            col_mem[wr_addr] <= col_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

endmodule

@@ rtl/two_color_pixel_plane_plotter.sv @@
// Top level of the two-color pixel plotter: controller plus datapath.
// Depends on tcpp_pkg, tcpp_ctrl and tcpp_datapath.
//
// Each item is handled in two steps: the accept edge reads both table bytes
// from the single-port memories, and the execute edge, taken once the result
// register is free, writes the modified bytes and loads the result register.
// A new item is not accepted until the last one has executed. The result
// register lets a new item be accepted while a finished result still waits.
// The pattern and color tables come up undefined and must be loaded with raw
// writes before pixels are read or drawn; there is no clearing pass.
module two_color_pixel_plane_plotter
    import tcpp_pkg::*;
#(
    parameter int TABLE_BYTES = 6144
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tcpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcpp_datapath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ rtl/tcpp_checker.sv @@
// Port-level assertions for the pixel plotter and the bind that attaches them.
// Depends on tcpp_pkg and the two_color_pixel_plane_plotter top level.
module tcpp_checker
    import tcpp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Each item is worked on alone, so an accept is followed by a busy cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in the cycle after an accept");

    // A raw read result never carries pixel fields.
    a_raw_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_byte != 8'd0 |->
            m_data.pixel_index == 4'd0 && m_data.pixel_rgb == 15'd0)
        else $error("table byte and pixel fields both nonzero");

    // Both low palette entries are black.
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.pixel_index == 4'd0 || m_data.pixel_index == 4'd1) |->
            m_data.pixel_rgb == 15'd0)
        else $error("black palette entry gave nonzero rgb");

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind two_color_pixel_plane_plotter tcpp_checker u_tcpp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/testbench.sv @@
// Self-checking testbench for two_color_pixel_plane_plotter: directed table, then random
// load-and-draw sequences with noise, checked against given results or an in-bench bitmap predictor.
// Depends on tcpp_pkg and the plotter RTL only.
module testbench;
    import tcpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_BYTES = 6144;
    localparam int PIXEL_ROWS = 192;
    localparam int ADDR_SPAN = 8192;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h000000, 24'h21c842, 24'h5edc78,
        24'h5455ed, 24'h7d76fc, 24'hd4524d, 24'h42ebf5,
        24'hfc5554, 24'hff7978, 24'hd4c154, 24'he6ce80,
        24'h21b03b, 24'hc95bba, 24'hcccccc, 24'hffffff
    };

    typedef struct {
        in_item_t  item;
        bit        known;
        out_item_t want;
    } directed_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Mirror of the two tables, plus which bytes have been written.
    logic [7:0] pattern_mirror [TABLE_BYTES];
    logic [7:0] color_mirror [TABLE_BYTES];
    bit         pattern_loaded [TABLE_BYTES];
    bit         color_loaded [TABLE_BYTES];
    bit         row_loaded [TABLE_BYTES];
    int         loaded_rows [$];

    out_item_t  expected_results [$];
    int         send_idle_pct = 20;
    int         recv_idle_pct = 83;
    int         fail_count = 0;
    int         results_seen = 0;
    int         cycle_count = 0;

    two_color_pixel_plane_plotter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [14:0] rgb555_of(input logic [3:0] idx);
        logic [7:0] red, green, blue;
        red   = PALETTE[idx][23:16];
        green = PALETTE[idx][15:8];
        blue  = PALETTE[idx][7:0];
        return {blue[7:3], green[7:3], red[7:3]};
    endfunction

    // Applies one item to the mirror and returns the result it should produce.
    function automatic out_item_t plot_predict(input in_item_t it);
        out_item_t  res;
        logic [12:0] a;
        logic [7:0] msk, pat, col;
        logic [3:0] fg, bg, nc;
        res = '0;
        nc = it.new_color;
        a = {it.pixel_y[7:3], it.pixel_x[7:3], it.pixel_y[2:0]};
        case (it.opcode)
            OP_READ_PIXEL, OP_PAINT, OP_RECOLOR: begin
                if (a < TABLE_BYTES) begin
                    msk = 8'h80 >> it.pixel_x[2:0];
                    pat = pattern_mirror[a];
                    col = color_mirror[a];
                    fg = col[7:4];
                    bg = col[3:0];
                    if (it.opcode == OP_PAINT) begin
                        if (fg == bg || pat == 8'h00) begin
                            col = {nc, bg};
                            pat = msk;
                        end else if (pat == 8'hFF) begin
                            col = {nc, fg};
                            pat = msk;
                        end else if (fg == nc) begin
                            pat = pat | msk;
                        end else if (bg == nc) begin
                            pat = pat & ~msk;
                        end else if ((pat & msk) != 8'h00) begin
                            col[7:4] = nc;
                        end else begin
                            col[3:0] = nc;
                        end
                    end else if (it.opcode == OP_RECOLOR) begin
                        if (fg == bg) begin
                            pat = 8'h00;
                        end
                        if ((pat & msk) != 8'h00) begin
                            col[7:4] = nc;
                        end else begin
                            col[3:0] = nc;
                        end
                    end
                    pattern_mirror[a] = pat;
                    color_mirror[a] = col;
                    res.pixel_index = ((pat & msk) != 8'h00) ? col[7:4] : col[3:0];
                    res.pixel_rgb = rgb555_of(res.pixel_index);
                end
            end
            OP_WRITE_BYTE: begin
                if (it.table_address < TABLE_BYTES) begin
                    if (it.table_select) begin
                        color_mirror[it.table_address] = it.table_data;
                        color_loaded[it.table_address] = 1'b1;
                    end else begin
                        pattern_mirror[it.table_address] = it.table_data;
                        pattern_loaded[it.table_address] = 1'b1;
                    end
                    if (pattern_loaded[it.table_address] && color_loaded[it.table_address]
                            && !row_loaded[it.table_address]) begin
                        row_loaded[it.table_address] = 1'b1;
                        loaded_rows.push_back(int'(it.table_address));
                    end
                end
            end
            OP_READ_BYTE: begin
                if (it.table_address < TABLE_BYTES) begin
                    res.table_byte = it.table_select ? color_mirror[it.table_address]
                                                     : pattern_mirror[it.table_address];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic directed_row_t row(input logic [2:0] op, input int x, input int y,
                                          input int nc, input int sel, input int addr,
                                          input int data, input bit known = 1'b0,
                                          input int idx = 0, input int rgb = 0,
                                          input int tbyte = 0);
        directed_row_t r;
        r.item.opcode        = op;
        r.item.pixel_x       = x[7:0];
        r.item.pixel_y       = y[7:0];
        r.item.new_color     = nc[3:0];
        r.item.table_select  = sel[0];
        r.item.table_address = addr[12:0];
        r.item.table_data    = data[7:0];
        r.known              = known;
        r.want.pixel_index   = idx[3:0];
        r.want.pixel_rgb     = rgb[14:0];
        r.want.table_byte    = tbyte[7:0];
        return r;
    endfunction

    // Raw table access; the pixel fields carry random junk.
    function automatic in_item_t raw_item(input logic [2:0] op, input logic sel,
                                          input logic [12:0] addr, input logic [7:0] data);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom});
        it.opcode = op;
        it.table_select = sel;
        it.table_address = addr;
        it.table_data = data;
        return it;
    endfunction

    // Random pixel operation inside one loaded byte row; the new color leans
    // toward the colors already there so the clash rule takes every branch.
    function automatic in_item_t pixel_item(input logic [12:0] a);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom});
        it.opcode = opcode_t'($urandom_range(OP_READ_PIXEL, OP_RECOLOR));
        it.pixel_x = {a[7:3], 3'($urandom_range(0, 7))};
        it.pixel_y = {a[12:8], a[2:0]};
        case ($urandom_range(0, 4))
            0: it.new_color = color_mirror[a][7:4];
            1: it.new_color = color_mirror[a][3:0];
            default: it.new_color = 4'($urandom);
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                  $realtime, results_seen, what, got, want);
    endtask

    task automatic send_item(input in_item_t it, input bit known = 1'b0,
                             input out_item_t want = '0);
        out_item_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = plot_predict(it);
        expected_results.push_back(known ? want : predicted);
    endtask

    task automatic drive_random(input int count);
        int          sent;
        logic [12:0] a;
        logic [7:0]  pat, col;
        bit          color_first;
        in_item_t    it;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 65 || loaded_rows.size() == 0) begin
                // Load one byte row of a cell, then draw on it back to back.
                if (loaded_rows.size() != 0 && $urandom_range(0, 2) == 0) begin
                    a = 13'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
                end else begin
                    a = 13'($urandom_range(0, TABLE_BYTES - 1));
                end
                case ($urandom_range(0, 3))
                    0: pat = 8'h00;
                    1: pat = 8'hFF;
                    default: pat = 8'($urandom);
                endcase
                col = 8'($urandom);
                if ($urandom_range(0, 2) == 0) begin
                    col[3:0] = col[7:4];
                end
                color_first = 1'($urandom);
                send_item(raw_item(OP_WRITE_BYTE, color_first, a, color_first ? col : pat));
                send_item(raw_item(OP_WRITE_BYTE, !color_first, a, color_first ? pat : col));
                sent += 2;
                repeat ($urandom_range(2, 10)) begin
                    send_item(pixel_item(a));
                    sent++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_item(raw_item(OP_READ_BYTE, 1'($urandom), a, 8'($urandom)));
                    sent++;
                end
            end else begin
                a = 13'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
                case ($urandom_range(0, 5))
                    0: it = pixel_item(a);
                    1: it = raw_item(OP_READ_BYTE, 1'($urandom), a, 8'($urandom));
                    2: it = raw_item(OP_WRITE_BYTE, 1'($urandom),
                                     13'($urandom_range(0, ADDR_SPAN - 1)), 8'($urandom));
                    3: it = raw_item(OP_READ_BYTE, 1'($urandom),
                                     13'($urandom_range(TABLE_BYTES, ADDR_SPAN - 1)),
                                     8'($urandom));
                    4: begin
                        it = in_item_t'({$urandom, $urandom});
                        it.opcode = opcode_t'($urandom_range(OP_READ_PIXEL, OP_RECOLOR));
                        it.pixel_y = 8'($urandom_range(PIXEL_ROWS, 255));
                    end
                    default: begin
                        it = in_item_t'({$urandom, $urandom});
                        it.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                    end
                endcase
                send_item(it);
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_data, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.pixel_index !== want.pixel_index) begin
                    report_mismatch("pixel_index", m_data.pixel_index, want.pixel_index);
                end
                if (m_data.pixel_rgb !== want.pixel_rgb) begin
                    report_mismatch("pixel_rgb", m_data.pixel_rgb, want.pixel_rgb);
                end
                if (m_data.table_byte !== want.table_byte) begin
                    report_mismatch("table_byte", m_data.table_byte, want.table_byte);
                end
            end
        end
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end else begin
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        directed_row_t directed_rows [$];
        directed_rows = {
            row(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 8'h00, 1'b1),
            row(OP_WRITE_BYTE, 0, 0, 0, 1, 0, 8'hF1, 1'b1),
            row(OP_READ_BYTE, 0, 0, 0, 1, 0, 0, 1'b1, 0, 0, 8'hF1),
            // Empty pattern shows the background, which is black.
            row(OP_READ_PIXEL, 0, 0, 0, 0, 0, 0, 1'b1, 1, 0, 0),
            row(OP_PAINT, 0, 0, 2, 0, 0, 0),
            row(OP_PAINT, 7, 0, 2, 0, 0, 0),
            row(OP_PAINT, 3, 0, 1, 0, 0, 0),
            row(OP_PAINT, 1, 0, 9, 0, 0, 0),
            row(OP_PAINT, 0, 0, 12, 0, 0, 0),
            row(OP_RECOLOR, 2, 0, 15, 0, 0, 0),
            row(OP_READ_BYTE, 0, 0, 0, 0, 0, 0),
            row(OP_WRITE_BYTE, 0, 0, 0, 0, 6143, 8'hFF, 1'b1),
            row(OP_WRITE_BYTE, 0, 0, 0, 1, 6143, 8'h5A, 1'b1),
            row(OP_READ_PIXEL, 255, 191, 0, 0, 0, 0),
            row(OP_PAINT, 255, 191, 0, 0, 0, 0),
            row(OP_WRITE_BYTE, 0, 0, 0, 1, 6143, 8'h77, 1'b1),
            row(OP_RECOLOR, 250, 191, 14, 0, 0, 0),
            row(OP_WRITE_BYTE, 0, 0, 0, 1, 6143, 8'h33, 1'b1),
            row(OP_PAINT, 248, 191, 4, 0, 0, 0),
            row(OP_READ_BYTE, 0, 0, 0, 1, 6143, 0),
            // Rows past the bitmap, addresses past the tables and unused
            // opcodes all leave the tables alone and answer with zeros.
            row(OP_READ_PIXEL, 0, 192, 0, 0, 0, 0, 1'b1),
            row(OP_PAINT, 255, 255, 15, 0, 0, 0, 1'b1),
            row(OP_WRITE_BYTE, 0, 0, 0, 1, 6144, 8'hFF, 1'b1),
            row(OP_READ_BYTE, 0, 0, 0, 0, 8191, 0, 1'b1),
            row(OP_UNUSED_LO, 255, 255, 15, 1, 8191, 8'hFF, 1'b1),
            row(OP_UNUSED_HI, 255, 255, 15, 1, 8191, 8'hFF, 1'b1)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
        end
        drive_random(600);

        send_idle_pct = 83;
        recv_idle_pct = 20;
        drive_random(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drive_random(600);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
